>>> hw/rtl/busu_pkg.sv
// Shared definitions for the bounded unique set store: field widths, request
// and status codes, and the command/status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package busu_pkg;

   localparam int REQ_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 6;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 6;

   localparam logic [REQ_W-1:0] OP_APPEND   = 3'd0;
   localparam logic [REQ_W-1:0] OP_REMOVE   = 3'd1;
   localparam logic [REQ_W-1:0] OP_CONTAINS = 3'd2;
   localparam logic [REQ_W-1:0] OP_READ     = 3'd3;
   localparam logic [REQ_W-1:0] OP_CLEAR    = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd4;

   localparam logic [VALUE_W-1:0] ALL_ONES = '1;

   // controller -> datapath
   typedef struct packed {
      logic load;      // capture request word, reset scan pointers
      logic scan;      // walk the list one entry per cycle
      logic read_pos;  // issue the single read for a position request
      logic finish;    // resolve result, update count, load response word
   } busu_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_scan;
      logic need_read;
      logic scan_done;
   } busu_status_type;

endpackage

`default_nettype wire

>>> hw/rtl/busu_channels.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on busu_pkg for field widths.
`default_nettype none

interface busu_req_if import busu_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [REQ_W-1:0]   req_type;
   logic [VALUE_W-1:0] value;
   logic [POS_W-1:0]   position;

   modport source (output valid, output req_type, output value, output position,
                   input ready);
   modport sink   (input valid, input req_type, input value, input position,
                   output ready);
endinterface

interface busu_rsp_if import busu_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [VALUE_W-1:0]  read_value;
   logic [COUNT_W-1:0]  count;

   modport source (output valid, output status, output read_value, output count,
                   input ready);
   modport sink   (input valid, input status, input read_value, input count,
                   output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bounded_unique_set_store.sv
// Top level of the bounded unique set store: controller plus datapath.
// Depends on busu_pkg, busu_channels, busu_controller, busu_datapath.
//
//   channel    dir   fields                          word moved
//   req_chan   in    req_type, value, position       one request
//   rsp_chan   out   status, read_value, count       one result per request
//
// Append, remove and contains walk the stored entries through the single
// RAM read port, one per cycle. Read, clear, append of zero and refused
// requests skip the walk. One request is in work at a time; the next is
// accepted while the previous response still waits.
// Synchronous reset empties the list; entry RAM contents are not cleared.
// A stalled response holds the block in its finish step until taken.
`default_nettype none

module bounded_unique_set_store import busu_pkg::*; #(
   parameter int CAPACITY = 32
) (
   input wire logic clock,
   input wire logic reset,
   busu_req_if.sink   req_chan,
   busu_rsp_if.source rsp_chan
);

   busu_cmd_type    cmd;
   busu_status_type stat;

   busu_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   busu_datapath #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_type       (req_chan.req_type),
      .req_value      (req_chan.value),
      .req_position   (req_chan.position),
      .rsp_status     (rsp_chan.status),
      .rsp_read_value (rsp_chan.read_value),
      .rsp_count      (rsp_chan.count)
   );

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.scan, cmd.read_pos, cmd.finish}))
      else $error("more than one datapath command at once");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while previous one still in work");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_chan.valid)
      else $error("finished result not presented");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.status == ST_FULL)) |->
         (rsp_chan.count == COUNT_W'(CAPACITY)))
      else $error("full status with count below capacity");

endmodule

`default_nettype wire

>>> hw/rtl/busu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module busu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/busu_datapath.sv
// Datapath of the set store: request registers, entry count, scan pointers,
// entry RAM and response registers. Depends on busu_pkg and busu_ram.
`default_nettype none

module busu_datapath import busu_pkg::*; #(
   parameter int CAPACITY = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire busu_cmd_type        cmd,
   output busu_status_type          stat,
   input  wire logic [REQ_W-1:0]    req_type,
   input  wire logic [VALUE_W-1:0]  req_value,
   input  wire logic [POS_W-1:0]    req_position,
   output logic      [STATUS_W-1:0] rsp_status,
   output logic      [VALUE_W-1:0]  rsp_read_value,
   output logic      [COUNT_W-1:0]  rsp_count
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   logic [REQ_W-1:0]    op_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       addr_ff;
   logic [AW-1:0]       tag_ff;
   logic                pend_ff;
   logic                found_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [VALUE_W-1:0]  rv_ff, rv_in;
   logic [COUNT_W-1:0]  cnt_out_ff;

   logic               full;
   logic [PW-1:0]      pos_ext;
   logic [PW-1:0]      cnt_ext;
   logic               pos_ok;
   logic               issue;
   logic               hit;
   logic               shift_wr;
   logic               append_wr;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [VALUE_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [VALUE_W-1:0] ram_rd_data;

   assign full    = (count_ff >= CAP_C);
   assign pos_ext = PW'(pos_ff);
   assign cnt_ext = PW'(count_ff);
   assign pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);

   assign issue     = cmd.scan && (addr_ff < count_ff);
   // first match only; after it, remove moves each later entry down one slot
   assign hit       = pend_ff && !found_ff && (ram_rd_data == value_ff);
   assign shift_wr  = pend_ff && found_ff && (op_ff == OP_REMOVE);
   assign append_wr = cmd.finish && (op_ff == OP_APPEND) && !full &&
                      !((value_ff != '0) && found_ff);

   assign ram_wr_en   = shift_wr || append_wr;
   assign ram_wr_addr = append_wr ? count_ff[AW-1:0] : (tag_ff - AW'(1));
   assign ram_wr_data = append_wr ? value_ff : ram_rd_data;
   assign ram_rd_en   = issue || cmd.read_pos;
   assign ram_rd_addr = cmd.read_pos ? AW'(pos_ext - PW'(1)) : addr_ff[AW-1:0];

   busu_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_entries (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      stat.need_scan = ((op_ff == OP_APPEND) && !full && (value_ff != '0)) ||
                       (op_ff == OP_REMOVE) ||
                       ((op_ff == OP_CONTAINS) && (value_ff != '0) && (count_ff != '0));
      stat.need_read = (op_ff == OP_READ) && pos_ok;
      stat.scan_done = (addr_ff >= count_ff) && !pend_ff;
   end

   always_comb begin
      status_in = ST_INVALID;
      rv_in     = ALL_ONES;
      count_in  = count_ff;
      unique case (op_ff)
         OP_APPEND: begin
            if (full) begin
               status_in = ST_FULL;
            end else if ((value_ff != '0) && found_ff) begin
               status_in = ST_DUP;
            end else begin
               status_in = ST_OK;
               count_in  = count_ff + CW'(1);
            end
         end
         OP_REMOVE: begin
            if (found_ff) begin
               status_in = ST_OK;
               rv_in     = value_ff;
               count_in  = count_ff - CW'(1);
            end else begin
               status_in = ST_NOTFOUND;
            end
         end
         OP_CONTAINS: begin
            if ((value_ff == '0) || (count_ff == '0)) begin
               status_in = ST_INVALID;
            end else if (found_ff) begin
               status_in = ST_OK;
            end else begin
               status_in = ST_NOTFOUND;
            end
         end
         OP_READ: begin
            if (pos_ok) begin
               status_in = ST_OK;
               rv_in     = ram_rd_data;
            end
         end
         OP_CLEAR: begin
            status_in = ST_OK;
            count_in  = '0;
         end
         default: begin
            status_in = ST_INVALID;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
         found_ff <= 1'b0;
         addr_ff  <= '0;
      end else begin
         if (cmd.load) begin
            addr_ff  <= '0;
            pend_ff  <= 1'b0;
            found_ff <= 1'b0;
         end else begin
            pend_ff <= issue;
            if (issue) begin
               addr_ff <= addr_ff + CW'(1);
            end
            if (hit) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_type;
         value_ff <= req_value;
         pos_ff   <= req_position;
      end
      if (issue) begin
         tag_ff <= addr_ff[AW-1:0];
      end
      if (cmd.finish) begin
         status_ff  <= status_in;
         rv_ff      <= rv_in;
         cnt_out_ff <= COUNT_W'(count_in);
      end
   end

   assign rsp_status     = status_ff;
   assign rsp_read_value = rv_ff;
   assign rsp_count      = cnt_out_ff;

endmodule

`default_nettype wire

>>> hw/rtl/busu_controller.sv
// Sequencer of the set store: accepts a request word, drives load, read, scan
// and finish commands, and owns the response valid flag. Depends on busu_pkg.
`default_nettype none

module busu_controller import busu_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire busu_status_type stat,
   output busu_cmd_type         cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_FINISH
   } state_type;

   state_type state_ff;
   logic      out_valid_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;

   always_comb begin
      cmd.load     = (state_ff == S_IDLE) && req_valid;
      cmd.scan     = (state_ff == S_SCAN);
      cmd.read_pos = (state_ff == S_DECODE) && stat.need_read;
      // hold the result until the response register is free
      cmd.finish   = (state_ff == S_FINISH) && (!out_valid_ff || rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_DECODE;
               end
            end
            S_DECODE: begin
               state_ff <= stat.need_scan ? S_SCAN : S_FINISH;
            end
            S_SCAN: begin
               if (stat.scan_done) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (cmd.finish) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
